// ===== hdl/c5zp_pkg.sv =====
// Shared constants and types for the 5x5 zero-padded convolution block.
package c5zp_pkg;

	localparam int MAX_WIDTH       = 1024;
	localparam int MAX_HEIGHT      = 1024;
	localparam int PIXEL_BITS      = 8;
	localparam int COEF_BITS       = 12;
	localparam int COEF_PITCH      = 12;
	localparam int KSIZE           = 5;
	localparam int LINES           = KSIZE - 1;
	localparam int OUT_BITS        = 25;
	localparam int CFG_BITS        = KSIZE * COEF_PITCH;
	localparam int IDX_BITS        = 3;
	localparam int DIM_BITS        = 11;
	localparam int FRAME_DIM_RESET = 1024;
	localparam int COL_BITS        = $clog2(MAX_WIDTH);
	localparam int POS_BITS        = $clog2(MAX_WIDTH * MAX_HEIGHT + 2 * MAX_WIDTH + 2);
	localparam int PROD_BITS       = PIXEL_BITS + 1 + COEF_BITS;
	localparam int ROW_BITS        = PROD_BITS + $clog2(KSIZE);
	localparam int SUM_BITS        = ROW_BITS + $clog2(KSIZE);

	typedef enum logic [IDX_BITS-1:0] {
		REG_COEF_0       = 3'd0,
		REG_COEF_1       = 3'd1,
		REG_COEF_2       = 3'd2,
		REG_COEF_3       = 3'd3,
		REG_COEF_4       = 3'd4,
		REG_FRAME_WIDTH  = 3'd5,
		REG_FRAME_HEIGHT = 3'd6
	} cfg_reg_t;

	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_DRAIN = 1'b1
	} op_t;

	typedef logic [PIXEL_BITS-1:0]                        pix_t;
	typedef logic [LINES-1:0][PIXEL_BITS-1:0]             lines_t;
	typedef logic [KSIZE-1:0][PIXEL_BITS-1:0]             vec_t;
	typedef logic [KSIZE-1:0][KSIZE-1:0][PIXEL_BITS-1:0]  win_t;
	typedef logic [KSIZE-1:0][CFG_BITS-1:0]               coef_bank_t;

	// per-item control carried alongside the pixel column
	typedef struct packed {
		logic             has_res;
		logic [KSIZE-1:0] row_ok;
		logic [KSIZE-1:0] col_ok;
		logic             last;
	} item_ctl_t;

endpackage

// ===== hdl/c5zp_lbuf.sv =====
// Four-line pixel buffer: one word per column, read-modify-write with bypass.
module c5zp_lbuf import c5zp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  logic [COL_BITS-1:0] rd_addr,
	input  logic                wr_en,
	input  logic [COL_BITS-1:0] wr_addr,
	input  lines_t              wr_data,
	output lines_t              rd_data
);

	lines_t mem [MAX_WIDTH];
	lines_t rd_q;
	lines_t fwd_data_q;
	logic   fwd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q       <= mem[rd_addr];
			fwd_data_q <= wr_data;
		end
	end

	// same column written and read in one cycle: take the new word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = fwd_q ? fwd_data_q : rd_q;

endmodule

// ===== hdl/c5zp_window.sv =====
// 5x5 window shift register and masked window snapshot stage.
module c5zp_window import c5zp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      shift_en,
	input  logic      load_en,
	input  vec_t      col_vec,
	input  item_ctl_t ctl,
	output logic      ready,
	output logic      snap_valid,
	input  logic      snap_ready,
	output win_t      snap,
	output logic      snap_last
);

	win_t win_q;
	win_t win_d;
	win_t masked;
	win_t snap_s2;
	logic last_s2;
	logic v_s2;

	always_comb begin
		for (int i = 0; i < KSIZE; i++) begin
			for (int j = 0; j < KSIZE - 1; j++) begin
				win_d[i][j] = win_q[i][j+1];
			end
			win_d[i][KSIZE-1] = col_vec[i];
		end
	end

	// zero padding: taps outside the frame read as zero
	always_comb begin
		for (int i = 0; i < KSIZE; i++) begin
			for (int j = 0; j < KSIZE; j++) begin
				masked[i][j] = (ctl.row_ok[i] && ctl.col_ok[j]) ? win_d[i][j] : '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			win_q <= win_d;
		end
		if (load_en) begin
			snap_s2 <= masked;
			last_s2 <= ctl.last;
		end
	end

	assign ready = !v_s2 || snap_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ready) begin
			v_s2 <= load_en;
		end
	end

	assign snap_valid = v_s2;
	assign snap       = snap_s2;
	assign snap_last  = last_s2;

endmodule

// ===== hdl/c5zp_mac.sv =====
// Multiply-accumulate pipeline: 25 products, row sums, total and result register.
module c5zp_mac import c5zp_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  win_t                       win,
	input  logic                       in_last,
	input  coef_bank_t                 coef,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [OUT_BITS-1:0] filtered,
	output logic                       frame_end
);

	logic signed [PROD_BITS-1:0] prod_d  [KSIZE][KSIZE];
	logic signed [PROD_BITS-1:0] prod_s3 [KSIZE][KSIZE];
	logic signed [ROW_BITS-1:0]  row_d   [KSIZE];
	logic signed [ROW_BITS-1:0]  row_s4  [KSIZE];
	logic signed [SUM_BITS-1:0]  total_d;
	logic signed [OUT_BITS-1:0]  res_q;
	logic                        last_s3;
	logic                        last_s4;
	logic                        end_q;
	logic                        v_s3;
	logic                        v_s4;
	logic                        out_valid_q;
	logic                        rdy3;
	logic                        rdy4;
	logic                        rdy_o;

	assign rdy_o    = !out_valid_q || out_ready;
	assign rdy4     = !v_s4 || rdy_o;
	assign rdy3     = !v_s3 || rdy4;
	assign in_ready = rdy3;

	always_comb begin
		for (int i = 0; i < KSIZE; i++) begin
			for (int j = 0; j < KSIZE; j++) begin
				prod_d[i][j] = PROD_BITS'($signed({1'b0, win[i][j]}))
					* PROD_BITS'($signed(coef[i][COEF_PITCH*j +: COEF_BITS]));
			end
		end
	end

	always_comb begin
		for (int i = 0; i < KSIZE; i++) begin
			row_d[i] = '0;
			for (int j = 0; j < KSIZE; j++) begin
				row_d[i] = row_d[i] + ROW_BITS'(prod_s3[i][j]);
			end
		end
	end

	always_comb begin
		total_d = '0;
		for (int i = 0; i < KSIZE; i++) begin
			total_d = total_d + SUM_BITS'(row_s4[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy3) begin
			prod_s3 <= prod_d;
			last_s3 <= in_last;
		end
		if (v_s3 && rdy4) begin
			row_s4  <= row_d;
			last_s4 <= last_s3;
		end
		if (v_s4 && rdy_o) begin
			res_q <= total_d[OUT_BITS-1:0];
			end_q <= last_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy3) begin
				v_s3 <= in_valid;
			end
			if (rdy4) begin
				v_s4 <= v_s3;
			end
			if (rdy_o) begin
				out_valid_q <= v_s4;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign filtered  = res_q;
	assign frame_end = end_q;

endmodule

// ===== hdl/conv2d_5x5_zero_pad.sv =====
// Top level of the streaming 5x5 zero-padded 2-D convolution.
//
// Pixels enter in raster order on the in_valid/in_ready channel, one transfer
// per pixel; opcode marks drain items that flush the frame tail. Results
// leave on out_valid/out_ready in raster order, frame_end set on the last.
// The result for a pixel belongs to the transfer 2*width+2 items later and
// leaves through the stage registers s1 to s4 and res_q. One item per cycle
// is sustained: an item enters on every cycle that the pipeline can move,
// set by the single line-buffer read and write port, one of each per cycle.
// Registers are written through cfg_we/cfg_index/cfg_data; the user must
// write them only while idle (not enforced). A write to the frame width or
// height restarts the frame. Reset clears the position counters, the pipeline
// and the registers (coefficients to zero, frame size to 1024x1024). The
// line buffer is not swept: any entry not yet written in this frame only
// feeds padded taps. When out_ready is low the stages fill one by one and
// in_ready drops once every stage holds an item; nothing is lost.
module conv2d_5x5_zero_pad import c5zp_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [IDX_BITS-1:0]        cfg_index,
	input  logic [CFG_BITS-1:0]        cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       opcode,
	input  logic [PIXEL_BITS-1:0]      pixel,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [OUT_BITS-1:0] filtered,
	output logic                       frame_end
);

	coef_bank_t          coef_q;
	logic [DIM_BITS-1:0] fwidth_q;
	logic [DIM_BITS-1:0] fheight_q;
	logic [DIM_BITS-1:0] w_eff;
	logic [DIM_BITS-1:0] h_eff;
	logic [DIM_BITS:0]   thr;

	logic [COL_BITS-1:0] in_col_q;
	logic [POS_BITS-1:0] pos_q;
	logic [DIM_BITS-1:0] out_row_q;
	logic [DIM_BITS-1:0] out_col_q;

	logic      drain;
	logic      active;
	logic      restart;
	item_ctl_t ctl_d;

	logic                v_s1;
	item_ctl_t           ctl_s1;
	logic [COL_BITS-1:0] col_s1;
	pix_t                px_s1;
	logic                s1_leave;

	lines_t lb_rd;
	lines_t lb_wr;
	vec_t   vec;

	logic win_ready;
	logic snap_valid;
	win_t snap;
	logic snap_last;
	logic mac_ready;

	always_comb begin
		if (fwidth_q == '0) begin
			w_eff = DIM_BITS'(1);
		end else if (fwidth_q > DIM_BITS'(MAX_WIDTH)) begin
			w_eff = DIM_BITS'(MAX_WIDTH);
		end else begin
			w_eff = fwidth_q;
		end
		if (fheight_q == '0) begin
			h_eff = DIM_BITS'(1);
		end else if (fheight_q > DIM_BITS'(MAX_HEIGHT)) begin
			h_eff = DIM_BITS'(MAX_HEIGHT);
		end else begin
			h_eff = fheight_q;
		end
	end

	assign thr = {w_eff, 1'b0} + (DIM_BITS+1)'(2);

	assign drain   = (op_t'(opcode) == OP_DRAIN);
	assign active  = in_valid && in_ready && !(drain && (pos_q == '0));
	assign restart = cfg_we && ((cfg_reg_t'(cfg_index) == REG_FRAME_WIDTH)
		|| (cfg_reg_t'(cfg_index) == REG_FRAME_HEIGHT));

	// output position masks and end of frame
	always_comb begin
		ctl_d.has_res   = pos_q >= POS_BITS'(thr);
		ctl_d.row_ok[0] = out_row_q >= DIM_BITS'(2);
		ctl_d.row_ok[1] = out_row_q >= DIM_BITS'(1);
		ctl_d.row_ok[2] = 1'b1;
		ctl_d.row_ok[3] = (out_row_q + DIM_BITS'(1)) < h_eff;
		ctl_d.row_ok[4] = (out_row_q + DIM_BITS'(2)) < h_eff;
		ctl_d.col_ok[0] = out_col_q >= DIM_BITS'(2);
		ctl_d.col_ok[1] = out_col_q >= DIM_BITS'(1);
		ctl_d.col_ok[2] = 1'b1;
		ctl_d.col_ok[3] = (out_col_q + DIM_BITS'(1)) < w_eff;
		ctl_d.col_ok[4] = (out_col_q + DIM_BITS'(2)) < w_eff;
		ctl_d.last      = (out_row_q == h_eff - DIM_BITS'(1))
			&& (out_col_q == w_eff - DIM_BITS'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q    <= '0;
			fwidth_q  <= DIM_BITS'(FRAME_DIM_RESET);
			fheight_q <= DIM_BITS'(FRAME_DIM_RESET);
			in_col_q  <= '0;
			pos_q     <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_COEF_0, REG_COEF_1, REG_COEF_2, REG_COEF_3, REG_COEF_4: begin
						coef_q[cfg_index] <= cfg_data;
					end
					REG_FRAME_WIDTH: begin
						fwidth_q <= cfg_data[DIM_BITS-1:0];
					end
					REG_FRAME_HEIGHT: begin
						fheight_q <= cfg_data[DIM_BITS-1:0];
					end
					default: begin
					end
				endcase
			end
			if (restart || (active && ctl_d.has_res && ctl_d.last)) begin
				in_col_q  <= '0;
				pos_q     <= '0;
				out_row_q <= '0;
				out_col_q <= '0;
			end else if (active) begin
				pos_q <= pos_q + POS_BITS'(1);
				if ((DIM_BITS'(in_col_q) + DIM_BITS'(1)) >= w_eff) begin
					in_col_q <= '0;
				end else begin
					in_col_q <= in_col_q + COL_BITS'(1);
				end
				if (ctl_d.has_res) begin
					if ((out_col_q + DIM_BITS'(1)) >= w_eff) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + DIM_BITS'(1);
					end else begin
						out_col_q <= out_col_q + DIM_BITS'(1);
					end
				end
			end
		end
	end

	// stage 1: line buffer read data arrives, column vector formed
	assign s1_leave = v_s1 && (!ctl_s1.has_res || win_ready);
	assign in_ready = !v_s1 || s1_leave;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= active;
		end
	end

	always_ff @(posedge clk) begin
		if (active) begin
			ctl_s1 <= ctl_d;
			col_s1 <= in_col_q;
			px_s1  <= drain ? '0 : pixel;
		end
	end

	always_comb begin
		for (int k = 0; k < LINES; k++) begin
			vec[k] = lb_rd[k];
		end
		vec[KSIZE-1] = px_s1;
		for (int k = 0; k < LINES; k++) begin
			lb_wr[k] = vec[k+1];
		end
	end

	c5zp_lbuf u_lbuf (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (active),
		.rd_addr (in_col_q),
		.wr_en   (s1_leave),
		.wr_addr (col_s1),
		.wr_data (lb_wr),
		.rd_data (lb_rd)
	);

	c5zp_window u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.shift_en   (s1_leave),
		.load_en    (s1_leave && ctl_s1.has_res),
		.col_vec    (vec),
		.ctl        (ctl_s1),
		.ready      (win_ready),
		.snap_valid (snap_valid),
		.snap_ready (mac_ready),
		.snap       (snap),
		.snap_last  (snap_last)
	);

	c5zp_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (snap_valid),
		.in_ready  (mac_ready),
		.win       (snap),
		.in_last   (snap_last),
		.coef      (coef_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.filtered  (filtered),
		.frame_end (frame_end)
	);

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the 5x5 zero-padded streaming convolution.
module testbench;
	import c5zp_pkg::*;

	localparam int HALF     = KSIZE / 2;
	localparam int SETTLE   = 20;
	localparam int HOLD_LEN = 600;
	localparam int N_RANDOM = 850;
	localparam int LIMIT_NS = 2_000_000;

	typedef struct {
		op_t  op;
		pix_t px;
	} pix_item_t;

	typedef struct {
		logic signed [OUT_BITS-1:0] sum;
		logic                       last;
	} conv_res_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_we = 1'b0;
	logic [IDX_BITS-1:0]        cfg_index = '0;
	logic [CFG_BITS-1:0]        cfg_data = '0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic                       opcode = OP_PIXEL;
	logic [PIXEL_BITS-1:0]      pixel = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic signed [OUT_BITS-1:0] filtered;
	logic                       frame_end;

	conv2d_5x5_zero_pad u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.pixel     (pixel),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.filtered  (filtered),
		.frame_end (frame_end)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// pixel stream waiting for the driver, and convolution sums still owed by the block
	pix_item_t pixel_q[$];
	conv_res_t sum_q[$];

	int unsigned n_pushed, n_taken, n_drains, n_results, n_frames, n_sizes, n_errors;

	// shadow of the filter state
	logic [CFG_BITS-1:0] m_coef [KSIZE];
	logic [DIM_BITS-1:0] m_width, m_height;
	pix_t                m_lines [LINES][MAX_WIDTH];
	pix_t                m_win [KSIZE][KSIZE];
	int unsigned         m_row, m_col, m_outs;

	function automatic int unsigned eff_dim(logic [DIM_BITS-1:0] v, int unsigned lim);
		if (v == 0)
			return 1;
		if (v > lim)
			return lim;
		return 32'(v);
	endfunction

	function automatic void restart_frame();
		m_row = 0;
		m_col = 0;
		m_outs = 0;
	endfunction

	function automatic void conv_step(op_t op, pix_t px_in);
		int unsigned w, h, col, r, c;
		longint pos, sum, kv, pv;
		int rr, cc;
		pix_t px;
		pix_t colv [KSIZE];
		logic signed [COEF_BITS-1:0] k;
		conv_res_t res;
		w = eff_dim(m_width, MAX_WIDTH);
		h = eff_dim(m_height, MAX_HEIGHT);
		px = (op == OP_DRAIN) ? pix_t'(0) : px_in;
		pos = longint'(m_row) * w + m_col;
		if (op == OP_DRAIN && pos == 0)
			return;
		col = (m_col < MAX_WIDTH) ? m_col : 0;
		for (int i = 0; i < LINES; i++)
			colv[i] = m_lines[i][col];
		colv[LINES] = px;
		for (int i = 0; i < LINES; i++)
			m_lines[i][col] = colv[i+1];
		for (int i = 0; i < KSIZE; i++) begin
			for (int j = 0; j < KSIZE - 1; j++)
				m_win[i][j] = m_win[i][j+1];
			m_win[i][KSIZE-1] = colv[i];
		end
		m_col++;
		if (m_col >= w) begin
			m_col = 0;
			m_row++;
		end
		if (pos < 2 * longint'(w) + 2)
			return;
		r = m_outs / w;
		c = m_outs % w;
		sum = 0;
		for (int i = 0; i < KSIZE; i++) begin
			rr = int'(r) - HALF + i;
			if (rr < 0 || rr >= int'(h))
				continue;
			for (int j = 0; j < KSIZE; j++) begin
				cc = int'(c) - HALF + j;
				if (cc < 0 || cc >= int'(w))
					continue;
				k = m_coef[i][j*COEF_PITCH +: COEF_BITS];
				kv = longint'(k);
				pv = longint'(m_win[i][j]);
				sum += kv * pv;
			end
		end
		res.sum = OUT_BITS'(sum);
		res.last = (longint'(m_outs) + 1 >= longint'(w) * h);
		sum_q.push_back(res);
		if (res.last)
			restart_frame();
		else
			m_outs++;
	endfunction

	// driver: bursts of transfers separated by random gaps
	pix_item_t   tx_item;
	int unsigned tx_burst, tx_gap;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			opcode   <= OP_PIXEL;
			pixel    <= '0;
			tx_burst = 1;
			tx_gap   = 0;
		end else begin
			if (in_valid && in_ready) begin
				if (opcode == OP_DRAIN)
					n_drains++;
				conv_step(op_t'(opcode), pixel);
				n_taken++;
			end
			if (!in_valid || in_ready) begin
				if (tx_gap != 0 || pixel_q.size() == 0) begin
					if (tx_gap != 0)
						tx_gap--;
					in_valid <= 1'b0;
				end else begin
					tx_item = pixel_q.pop_front();
					in_valid <= 1'b1;
					opcode   <= tx_item.op;
					pixel    <= tx_item.px;
					tx_burst--;
					if (tx_burst == 0) begin
						tx_burst = $urandom_range(1, 64);
						tx_gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
					end
				end
			end
		end
	end

	// long receiver hold-off, counted here
	logic        hold_go = 1'b0;
	int unsigned hold_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_left <= 0;
		else if (hold_go)
			hold_left <= HOLD_LEN;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// monitor: checks each result transfer against the oldest owed sum
	conv_res_t   rx_want;
	int unsigned rx_cycle, rx_mode;
	bit          rx_go;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_cycle = 0;
			rx_mode  = 0;
		end else begin
			if (out_valid && out_ready) begin
				n_results++;
				if (frame_end)
					n_frames++;
				if (sum_q.size() == 0) begin
					if (n_errors < 10)
						$display("%0t: unexpected result filtered=%0d frame_end=%0b",
							$time, filtered, frame_end);
					n_errors++;
				end else begin
					rx_want = sum_q.pop_front();
					if (filtered !== rx_want.sum || frame_end !== rx_want.last) begin
						if (n_errors < 10)
							$display("%0t: result %0d filtered=%0d (exp %0d) frame_end=%0b (exp %0b)",
								$time, n_results, filtered, rx_want.sum, frame_end,
								rx_want.last);
						n_errors++;
					end
				end
			end
			rx_cycle++;
			if (rx_cycle % 128 == 0)
				rx_mode = $urandom_range(0, 3);
			case (rx_mode)
				0: rx_go = 1'b1;
				1: rx_go = $urandom_range(0, 9) < 7;
				2: rx_go = rx_cycle[0];
				default: rx_go = $urandom_range(0, 9) < 3;
			endcase
			out_ready <= (hold_left == 0) && rx_go;
		end
	end

	function automatic void push_item(op_t op, pix_t px);
		pixel_q.push_back('{op, px});
		n_pushed++;
	endfunction

	task automatic wait_idle();
		while (n_taken != n_pushed || sum_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_BITS-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_FRAME_WIDTH: begin
				m_width = val[DIM_BITS-1:0];
				restart_frame();
				n_sizes++;
			end
			REG_FRAME_HEIGHT: begin
				m_height = val[DIM_BITS-1:0];
				restart_frame();
				n_sizes++;
			end
			default: m_coef[int'(idx)] = val;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [CFG_BITS-1:0] coef_pattern();
		case ($urandom_range(0, 5))
			0: return {KSIZE{12'h800}};
			1: return {KSIZE{12'h7FF}};
			2: return '0;
			default: return CFG_BITS'({$urandom, $urandom});
		endcase
	endfunction

	// one frame in raster order plus its tail; keep of zero sends it whole
	task automatic push_frame(int unsigned w, int unsigned h, int unsigned drain_pct,
			int unsigned pause_at, int unsigned keep);
		int unsigned total;
		total = w * h + 2 * w + 2;
		if (keep == 0 || keep > total)
			keep = total;
		for (int unsigned k = 0; k < keep; k++) begin
			if (pause_at != 0 && k == pause_at)
				wait_idle();
			if (k >= w * h)
				push_item($urandom_range(0, 1) ? OP_DRAIN : OP_PIXEL,
					pix_t'($urandom_range(0, 255)));
			else if (k != 0 && $urandom_range(0, 99) < drain_pct)
				push_item(OP_DRAIN, pix_t'($urandom_range(0, 255)));
			else
				push_item(OP_PIXEL, pix_t'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		#(LIMIT_NS);
		$display("TEST FAILED");
		$finish;
	end

	initial begin : stim
		logic [DIM_BITS-1:0] wv, hv;
		int unsigned w, h, phase, frames, base, ignored, total, pause_at, keep;
		for (int i = 0; i < LINES; i++)
			for (int j = 0; j < MAX_WIDTH; j++)
				m_lines[i][j] = '0;
		for (int i = 0; i < KSIZE; i++) begin
			m_coef[i] = '0;
			for (int j = 0; j < KSIZE; j++)
				m_win[i][j] = '0;
		end
		m_width  = FRAME_DIM_RESET;
		m_height = FRAME_DIM_RESET;
		restart_frame();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extreme coefficients on a 3x2 frame
		write_reg(REG_COEF_0, {KSIZE{12'h800}});
		write_reg(REG_COEF_1, {KSIZE{12'h7FF}});
		write_reg(REG_COEF_2, {12'h000, 12'hFFF, 12'h001, 12'h800, 12'h7FF});
		write_reg(REG_COEF_3, {KSIZE{12'h7FF}});
		write_reg(REG_COEF_4, {KSIZE{12'h800}});
		write_reg(REG_FRAME_WIDTH, CFG_BITS'(3));
		write_reg(REG_FRAME_HEIGHT, CFG_BITS'(2));
		push_item(OP_DRAIN, 8'hFF);
		push_item(OP_PIXEL, 8'hFF);
		push_item(OP_PIXEL, 8'h00);
		push_item(OP_DRAIN, 8'hAA);
		push_item(OP_PIXEL, 8'hAA);
		push_item(OP_PIXEL, 8'h55);
		push_item(OP_PIXEL, 8'hFF);
		push_item(OP_PIXEL, 8'h55);
		push_item(OP_DRAIN, 8'h00);
		push_item(OP_PIXEL, 8'hAA);
		push_item(OP_DRAIN, 8'hFF);
		push_item(OP_DRAIN, 8'h55);
		push_item(OP_PIXEL, 8'hFF);
		push_item(OP_DRAIN, 8'hAA);
		push_item(OP_PIXEL, 8'h00);
		// partial frame, then a size write restarts it
		for (int k = 0; k < 4; k++)
			push_item(OP_PIXEL, 8'hFF);
		wait_idle();
		write_reg(REG_FRAME_HEIGHT, CFG_BITS'(2));
		push_frame(3, 2, 0, 0, 0);
		wait_idle();

		// size extremes
		for (int i = 0; i < KSIZE; i++)
			write_reg(cfg_reg_t'(i), coef_pattern());
		write_reg(REG_FRAME_WIDTH, CFG_BITS'(7));
		write_reg(REG_FRAME_HEIGHT, '0);
		push_frame(7, 1, 3, 0, 0);
		wait_idle();
		write_reg(REG_FRAME_WIDTH, '0);
		write_reg(REG_FRAME_HEIGHT, CFG_BITS'((1 << DIM_BITS) - 1));
		push_frame(1, MAX_HEIGHT, 3, 0, 0);
		wait_idle();

		// random phases
		base = n_pushed;
		ignored = 0;
		phase = 0;
		while (phase < 3 || n_pushed - base - ignored < N_RANDOM) begin
			phase++;
			for (int i = 0; i < KSIZE; i++)
				if (phase == 1 || $urandom_range(0, 2) == 0)
					write_reg(cfg_reg_t'(i), coef_pattern());
			case ($urandom_range(0, 9))
				0: wv = '0;
				1: wv = DIM_BITS'($urandom_range(13, 64));
				default: wv = DIM_BITS'($urandom_range(1, 12));
			endcase
			if (wv > 12)
				hv = DIM_BITS'($urandom_range(0, 3));
			else
				case ($urandom_range(0, 9))
					0: hv = '0;
					1: hv = DIM_BITS'($urandom_range(9, 20));
					default: hv = DIM_BITS'($urandom_range(1, 8));
				endcase
			if (phase == 3) begin
				wv = DIM_BITS'(8);
				hv = DIM_BITS'(30);
			end
			write_reg(REG_FRAME_WIDTH, CFG_BITS'(wv));
			write_reg(REG_FRAME_HEIGHT, CFG_BITS'(hv));
			w = eff_dim(wv, MAX_WIDTH);
			h = eff_dim(hv, MAX_HEIGHT);
			total = w * h + 2 * w + 2;
			if (phase == 3) begin
				@(posedge clk);
				hold_go <= 1'b1;
				@(posedge clk);
				hold_go <= 1'b0;
			end
			frames = $urandom_range(1, 3);
			for (int f = 0; f < frames; f++) begin
				if ($urandom_range(0, 4) == 0) begin
					push_item(OP_DRAIN, pix_t'($urandom_range(0, 255)));
					ignored++;
				end
				pause_at = ($urandom_range(0, 4) == 0) ? $urandom_range(1, total - 1) : 0;
				keep = (f == frames - 1 && $urandom_range(0, 5) == 0) ?
					$urandom_range(1, total - 1) : 0;
				push_frame(w, h, ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20),
					pause_at, keep);
			end
			wait_idle();
		end

		$display("covered %0d input transfers (%0d drains) and %0d checked results in %0d frames",
			n_taken, n_drains, n_results, n_frames);
		$display("%0d frame-size writes over %0d random phases, %0d mismatches",
			n_sizes, phase, n_errors);
		if (n_errors == 0 && sum_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/c5zp_pkg.sv
hdl/c5zp_lbuf.sv
hdl/c5zp_window.sv
hdl/c5zp_mac.sv
hdl/conv2d_5x5_zero_pad.sv
tb/testbench.sv
